>>> src/slsh_pkg.sv
// ----------------------------------------------------------------------------
// slsh_pkg
// shared widths, register codes, reset values, types and the glyph ramp
// of the sphere lambert shade unit
// ----------------------------------------------------------------------------
`default_nettype none

package slsh_pkg;

  // payload and register widths
  localparam int PosW      = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 31;
  localparam int RadSqW    = 31;
  localparam int InvRW     = 17;
  localparam int LightW    = 16;
  localparam int AmbW      = 12;
  localparam int GainW     = 13;
  localparam int LevelW    = 4;
  localparam int GlyphW    = 8;

  // datapath widths
  localparam int SqW       = 31;  // px*px, at most 2^30
  localparam int D2W       = 32;
  localparam int NormMagW  = 23;  // (16b magnitude * 17b reciprocal) >> 10
  localparam int NormW     = 24;
  localparam int SqrtRootW = 16;
  localparam int SqrtInW   = 2 * SqrtRootW;
  localparam int SqrtRemW  = SqrtRootW + 2;
  localparam int SqrtStepsDefault = 2;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegRadiusSq  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegInvRadius = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLightX    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLightY    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLightZ    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegAmbient   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegGain      = 3'd6;

  // register reset values
  localparam logic [RadSqW-1:0]        RstRadiusSq  = 31'd26214400;
  localparam logic [InvRW-1:0]         RstInvRadius = 17'd3277;
  localparam logic signed [LightW-1:0] RstLightX    = 16'sd11585;
  localparam logic signed [LightW-1:0] RstLightY    = -16'sd11585;
  localparam logic signed [LightW-1:0] RstLightZ    = 16'sd0;
  localparam logic [AmbW-1:0]          RstAmbient   = 12'd256;
  localparam logic [GainW-1:0]         RstGain      = 13'd2688;

  localparam logic [LevelW-1:0] LevelMax = 4'd12;

  // glyph codes
  localparam logic [GlyphW-1:0] GlyphSpace = 8'h20;
  localparam logic [GlyphW-1:0] GlyphDot   = 8'h2e;
  localparam logic [GlyphW-1:0] GlyphComma = 8'h2c;
  localparam logic [GlyphW-1:0] GlyphLowO  = 8'h6f;
  localparam logic [GlyphW-1:0] GlyphZero  = 8'h30;

  // sideband that rides along the square root pipeline
  typedef struct packed {
    logic                    in_disc;
    logic signed [NormW-1:0] nx;
    logic signed [NormW-1:0] ny;
  } slsh_side_t;

  function automatic logic [GlyphW-1:0] ramp_glyph(input logic [LevelW-1:0] lvl);
    logic [GlyphW-1:0] g;
    case (lvl) inside
      [4'd1:4'd3]:   g = GlyphDot;
      [4'd4:4'd6]:   g = GlyphComma;
      [4'd7:4'd9]:   g = GlyphLowO;
      [4'd10:4'd12]: g = GlyphZero;
      default:       g = GlyphSpace;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

>>> src/sphere_lambert_shade_unit.sv
// ----------------------------------------------------------------------------
// sphere_lambert_shade_unit
// lambert shading of one pixel of a lit sphere, fixed point, fully pipelined
// ----------------------------------------------------------------------------
// The unit takes one pixel request per clock and returns one result per
// request, in order. Each request passes through the registered capture,
// squaring, disc test, square root (two root bits per stage by default),
// normal scaling, light product, dot product, gain multiply and level
// stages. Throughput is one pixel per clock. All stages move together:
// when the output register holds a result that is not taken, the whole
// pipeline holds and in_ready_o drops, so nothing is lost or repeated.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i and
// must only change while no request is in flight; unknown indexes are ignored.
`default_nettype none

module sphere_lambert_shade_unit
  import slsh_pkg::*;
#(
  parameter int SqrtStepsPerStage = SqrtStepsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  // pixel request
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [PosW-1:0]     pos_x_i,
  input  wire logic [PosW-1:0]     pos_y_i,
  // shade result
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     inside_res_o,
  output logic [LevelW-1:0]        level_o,
  output logic [GlyphW-1:0]        glyph_o
);

  localparam int ProdW  = LightW + NormW;       // one light * normal term
  localparam int DotW   = ProdW + 2;            // sum of three terms
  localparam int NegW   = DotW - 1;             // magnitude of a negative dot
  localparam int GProdW = NegW + GainW;
  localparam int DiffW  = GProdW - 28;          // diffuse, Q.8
  localparam int TotW   = DiffW + 1;
  localparam int QuotW  = TotW - 8 + 1;

  // (|c| * inv_radius) >> 10
  function automatic logic [NormMagW-1:0] norm_mag(input logic [PosW-1:0] mag,
                                                   input logic [InvRW-1:0] inv);
    logic [PosW+InvRW-1:0] prod;
    prod = (PosW+InvRW)'(mag) * (PosW+InvRW)'(inv);
    return prod[PosW+InvRW-1:10];
  endfunction

  // signed coordinate to signed normal component, truncated toward zero
  function automatic logic signed [NormW-1:0] norm_signed(input logic [PosW-1:0] c,
                                                          input logic [InvRW-1:0] inv);
    logic [PosW-1:0]     mag;
    logic [NormMagW-1:0] p;
    mag = c[PosW-1] ? PosW'(-c) : c;
    p   = norm_mag(mag, inv);
    return c[PosW-1] ? -$signed({1'b0, p}) : $signed({1'b0, p});
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [RadSqW-1:0]        radius_sq_q;
  logic [InvRW-1:0]         inv_radius_q;
  logic signed [LightW-1:0] light_x_q, light_y_q, light_z_q;
  logic [AmbW-1:0]          ambient_q;
  logic [GainW-1:0]         gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_sq_q  <= RstRadiusSq;
      inv_radius_q <= RstInvRadius;
      light_x_q    <= RstLightX;
      light_y_q    <= RstLightY;
      light_z_q    <= RstLightZ;
      ambient_q    <= RstAmbient;
      gain_q       <= RstGain;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRadiusSq:  radius_sq_q  <= cfg_wdata_i[RadSqW-1:0];
        RegInvRadius: inv_radius_q <= cfg_wdata_i[InvRW-1:0];
        RegLightX:    light_x_q    <= cfg_wdata_i[LightW-1:0];
        RegLightY:    light_y_q    <= cfg_wdata_i[LightW-1:0];
        RegLightZ:    light_z_q    <= cfg_wdata_i[LightW-1:0];
        RegAmbient:   ambient_q    <= cfg_wdata_i[AmbW-1:0];
        RegGain:      gain_q       <= cfg_wdata_i[GainW-1:0];
        default:      ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // global advance: every stage moves when the output slot is free or drained
  // ---------------------------------------------------------------------------
  logic adv;
  logic out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // stage a: capture the pixel
  logic            a_valid_q;
  logic [PosW-1:0] a_px_q, a_py_q;

  // stage b: squares and in-plane normal components
  logic                    b_valid_q;
  logic [SqW-1:0]          b_sqx_q, b_sqy_q;
  logic signed [NormW-1:0] b_nx_q, b_ny_q;
  logic signed [2*PosW-1:0] b_sqx_d, b_sqy_d;

  // stage c: disc test and radicand
  logic                    c_valid_q;
  logic [SqrtInW-1:0]      c_diff_q;
  slsh_side_t              c_side_q;
  logic [D2W-1:0]          c_d2_d;
  logic                    c_inside_d;

  // square root output
  logic                    r_valid;
  logic [SqrtRootW-1:0]    r_root;
  slsh_side_t              r_side;

  // stage d: depth normal component
  logic                    d_valid_q;
  slsh_side_t              d_side_q;
  logic signed [NormW-1:0] d_nz_q;
  logic [NormMagW-1:0]     d_nz_mag_d;

  // stage e: light * normal terms
  logic                    e_valid_q, e_inside_q;
  logic signed [ProdW-1:0] e_px_q, e_py_q, e_pz_q;

  // stage f: negated dot product, clamped at zero
  logic                    f_valid_q, f_inside_q;
  logic [NegW-1:0]         f_neg_q;
  logic signed [DotW-1:0]  f_dot_d;

  // stage g: diffuse term
  logic                    g_valid_q, g_inside_q;
  logic [DiffW-1:0]        g_diff_q;
  logic [GProdW-1:0]       g_prod_d;

  // output stage
  logic [TotW-1:0]         h_total_d;
  logic [QuotW-1:0]        h_quot_d;
  logic [LevelW-1:0]       h_level_d;
  logic                    inside_q;
  logic [LevelW-1:0]       level_q;
  logic [GlyphW-1:0]       glyph_q;

  // ---------------------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------------------
  assign b_sqx_d = $signed(a_px_q) * $signed(a_px_q);
  assign b_sqy_d = $signed(a_py_q) * $signed(a_py_q);

  assign c_d2_d     = D2W'(b_sqx_q) + D2W'(b_sqy_q);
  assign c_inside_d = c_d2_d < D2W'(radius_sq_q);

  slsh_sqrt #(
    .StepsPerStage (SqrtStepsPerStage)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (c_valid_q),
    .rad_i   (c_diff_q),
    .side_i  (c_side_q),
    .valid_o (r_valid),
    .root_o  (r_root),
    .side_o  (r_side)
  );

  // z is the negated root, so its normal component is the negated magnitude
  assign d_nz_mag_d = norm_mag(r_root, inv_radius_q);

  assign f_dot_d = DotW'(e_px_q) + DotW'(e_py_q) + DotW'(e_pz_q);

  assign g_prod_d = GProdW'(f_neg_q) * GProdW'(gain_q);

  // level = min(12, ceil(total / 256)), zero outside the disc
  assign h_total_d = TotW'(ambient_q) + TotW'(g_diff_q);
  assign h_quot_d  = QuotW'(h_total_d[TotW-1:8]) + QuotW'(|h_total_d[7:0]);

  always_comb begin
    if (!g_inside_q) begin
      h_level_d = '0;
    end else if (h_quot_d > QuotW'(LevelMax)) begin
      h_level_d = LevelMax;
    end else begin
      h_level_d = h_quot_d[LevelW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // valid bits
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      e_valid_q   <= 1'b0;
      f_valid_q   <= 1'b0;
      g_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q   <= in_valid_i;
      b_valid_q   <= a_valid_q;
      c_valid_q   <= b_valid_q;
      d_valid_q   <= r_valid;
      e_valid_q   <= d_valid_q;
      f_valid_q   <= e_valid_q;
      g_valid_q   <= f_valid_q;
      out_valid_q <= g_valid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_px_q <= pos_x_i;
      a_py_q <= pos_y_i;

      b_sqx_q <= b_sqx_d[SqW-1:0];
      b_sqy_q <= b_sqy_d[SqW-1:0];
      b_nx_q  <= norm_signed(a_px_q, inv_radius_q);
      b_ny_q  <= norm_signed(a_py_q, inv_radius_q);

      // radicand only meaningful inside the disc, where d2 < radius_sq
      c_diff_q         <= SqrtInW'(radius_sq_q - c_d2_d[RadSqW-1:0]);
      c_side_q.in_disc <= c_inside_d;
      c_side_q.nx      <= b_nx_q;
      c_side_q.ny      <= b_ny_q;

      d_side_q <= r_side;
      d_nz_q   <= -$signed({1'b0, d_nz_mag_d});

      e_inside_q <= d_side_q.in_disc;
      e_px_q     <= light_x_q * d_side_q.nx;
      e_py_q     <= light_y_q * d_side_q.ny;
      e_pz_q     <= light_z_q * d_nz_q;

      f_inside_q <= e_inside_q;
      f_neg_q    <= f_dot_d[DotW-1] ? NegW'(-f_dot_d) : '0;

      g_inside_q <= f_inside_q;
      g_diff_q   <= g_prod_d[GProdW-1:28];

      inside_q <= g_inside_q;
      level_q  <= h_level_d;
      glyph_q  <= ramp_glyph(h_level_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;
  assign level_o      = level_q;
  assign glyph_o      = glyph_q;

endmodule

`default_nettype wire

>>> src/slsh_sqrt.sv
// ----------------------------------------------------------------------------
// slsh_sqrt
// pipelined floor integer square root, StepsPerStage result bits per stage,
// with a valid bit and sideband carried alongside
// ----------------------------------------------------------------------------
`default_nettype none

module slsh_sqrt
  import slsh_pkg::*;
#(
  parameter int StepsPerStage = SqrtStepsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [SqrtInW-1:0]   rad_i,
  input  wire slsh_side_t           side_i,
  output logic                      valid_o,
  output logic [SqrtRootW-1:0]      root_o,
  output slsh_side_t                side_o
);

  localparam int NumStages = SqrtRootW / StepsPerStage;

  logic                 valid_q [NumStages];
  logic [SqrtInW-1:0]   rad_q   [NumStages];
  logic [SqrtRemW-1:0]  rem_q   [NumStages];
  logic [SqrtRootW-1:0] root_q  [NumStages];
  slsh_side_t           side_q  [NumStages];

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    logic                 v_in;
    logic [SqrtInW-1:0]   rad_in;
    logic [SqrtRemW-1:0]  rem_in;
    logic [SqrtRootW-1:0] root_in;
    slsh_side_t           side_in;
    logic [SqrtInW-1:0]   rad_d;
    logic [SqrtRemW-1:0]  rem_d;
    logic [SqrtRootW-1:0] root_d;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
    end

    // restoring digit recurrence, two radicand bits per step
    always_comb begin
      logic [SqrtRemW+1:0] cur;
      logic [SqrtRemW+1:0] trial;
      rad_d  = rad_in;
      rem_d  = rem_in;
      root_d = root_in;
      for (int k = 0; k < StepsPerStage; k++) begin
        cur   = {rem_d, rad_d[SqrtInW-1 -: 2]};
        trial = {{(SqrtRemW - SqrtRootW){1'b0}}, root_d, 2'b01};
        if (cur >= trial) begin
          rem_d  = SqrtRemW'(cur - trial);
          root_d = {root_d[SqrtRootW-2:0], 1'b1};
        end else begin
          rem_d  = cur[SqrtRemW-1:0];
          root_d = {root_d[SqrtRootW-2:0], 1'b0};
        end
        rad_d = {rad_d[SqrtInW-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s]  <= rad_d;
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[NumStages-1];
  assign root_o  = root_q[NumStages-1];
  assign side_o  = side_q[NumStages-1];

endmodule

`default_nettype wire

>>> src/slsh_checker.sv
// ----------------------------------------------------------------------------
// slsh_checker
// port-level checks of the sphere lambert shade unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module slsh_checker
  import slsh_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire logic                inside_res_o,
  input wire logic [LevelW-1:0]   level_o,
  input wire logic [GlyphW-1:0]   glyph_o
);

  // a held result stays presented
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an empty output slot never blocks new requests
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // outside the disc the result is dark
  a_outside_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !inside_res_o |-> level_o == 4'd0 && glyph_o == GlyphSpace)
    else $error("outside pixel not dark");

  // level saturates
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_o <= LevelMax)
    else $error("level above maximum");

  // glyph follows the ramp for the level shown
  a_glyph_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (level_o == 4'd0 && glyph_o == GlyphSpace) ||
      (level_o >= 4'd1 && level_o <= 4'd3 && glyph_o == GlyphDot) ||
      (level_o >= 4'd4 && level_o <= 4'd6 && glyph_o == GlyphComma) ||
      (level_o >= 4'd7 && level_o <= 4'd9 && glyph_o == GlyphLowO) ||
      (level_o >= 4'd10 && level_o <= 4'd12 && glyph_o == GlyphZero))
    else $error("glyph does not match level");

endmodule

bind sphere_lambert_shade_unit slsh_checker u_slsh_checker (.*);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sphere lambert shade unit: pixel requests go
// in under random source gaps and sink stalls, bar the last phase; every
// shade result is checked field by field against a fixed-point shading
// predictor that tracks the registers, over a directed set and ten settings
// ----------------------------------------------------------------------------

module tb;
  import slsh_pkg::*;

  localparam int CycleLimit      = 200000;
  localparam int PhaseCount      = 10;
  localparam int PixelsPerPhase  = 113;
  localparam int DrainCycles     = 24;   // pipeline depth is 16 with the default root steps
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  typedef struct packed {
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic              in_disc;
    logic [LevelW-1:0] level;
    logic [GlyphW-1:0] glyph;
  } shade_t;

  // clock, reset and block inputs, all known from time zero
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx     = '0;
  logic [CfgDataW-1:0] cfg_wdata   = '0;
  logic                in_valid    = 1'b0;
  logic [PosW-1:0]     pos_x       = '0;
  logic [PosW-1:0]     pos_y       = '0;
  logic                out_ready   = 1'b0;

  logic                in_ready;
  logic                out_valid;
  logic                inside_res;
  logic [LevelW-1:0]   level;
  logic [GlyphW-1:0]   glyph;

  // register copies used by the predictor
  logic [RadSqW-1:0]        m_radius_sq  = RstRadiusSq;
  logic [InvRW-1:0]         m_inv_radius = RstInvRadius;
  logic signed [LightW-1:0] m_light_x    = RstLightX;
  logic signed [LightW-1:0] m_light_y    = RstLightY;
  logic signed [LightW-1:0] m_light_z    = RstLightZ;
  logic [AmbW-1:0]          m_ambient    = RstAmbient;
  logic [GainW-1:0]         m_gain       = RstGain;

  pixel_t pixel_q[$];   // requests not yet driven
  shade_t shade_q[$];   // shades owed by the block, oldest first
  pixel_t next_pixel;
  shade_t want_shade;
  shade_t got_shade;

  int  pixels_queued = 0;
  int  pixels_taken  = 0;
  int  mismatch_cnt  = 0;
  int  cycle_cnt     = 0;
  int  src_gap       = 0;
  int  snk_gap       = 0;
  bit  req_taken     = 1'b0;
  bit  idle_on       = 1'b1;

  sphere_lambert_shade_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .pos_x_i      (pos_x),
    .pos_y_i      (pos_y),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .inside_res_o (inside_res),
    .level_o      (level),
    .glyph_o      (glyph)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shading predictor
  // ---------------------------------------------------------------------------

  // floor square root, the argument stays below 2^32
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned cand;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= v) root = cand;
    end
    return root;
  endfunction

  // normal component in Q1.14, truncated toward zero
  function automatic longint scaled_normal(longint c);
    longint unsigned mag;
    longint unsigned prod;
    mag  = (c < 0) ? -c : c;
    prod = (mag * m_inv_radius) >> 10;
    return (c < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic logic [GlyphW-1:0] level_glyph(longint unsigned lvl);
    case (lvl)
      0:       return GlyphSpace;
      1, 2, 3: return GlyphDot;
      4, 5, 6: return GlyphComma;
      7, 8, 9: return GlyphLowO;
      default: return GlyphZero;
    endcase
  endfunction

  function automatic shade_t shade_pixel(logic signed [PosW-1:0] x, logic signed [PosW-1:0] y);
    longint          px;
    longint          py;
    longint          dot;
    longint unsigned d2;
    longint unsigned diffuse;
    longint unsigned total;
    longint unsigned lvl;
    shade_t          res;
    px  = x;
    py  = y;
    d2  = px * px + py * py;
    res = '{in_disc: 1'b0, level: '0, glyph: level_glyph(0)};
    if (d2 < m_radius_sq) begin
      // surface point faces the viewer, so z is the negative root
      dot = longint'(m_light_x) * scaled_normal(px)
          + longint'(m_light_y) * scaled_normal(py)
          + longint'(m_light_z) * scaled_normal(-longint'(floor_sqrt(m_radius_sq - d2)));
      diffuse = 0;
      if (dot < 0) diffuse = (unsigned'(-dot) * m_gain) >> 28;
      total = m_ambient + diffuse;
      lvl   = (total + 255) >> 8;
      if (lvl > LevelMax) lvl = LevelMax;
      res.in_disc = 1'b1;
      res.level   = lvl[LevelW-1:0];
      res.glyph   = level_glyph(lvl);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: one payload change per falling edge, held until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (src_gap != 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (idle_on && pixel_q.size() != 0 && $urandom_range(0, 7) == 0) begin
        // idle burst, this one included, its remaining length drawn into src_gap
        src_gap = $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        next_pixel = pixel_q.pop_front();
        in_valid <= 1'b1;
        pos_x    <= next_pixel.x;
        pos_y    <= next_pixel.y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result sink with random stall bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (snk_gap != 0) begin
      snk_gap--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      snk_gap = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on every accepted request, checks every accepted result
  // ---------------------------------------------------------------------------
  task automatic flag_field(input string what, input logic [GlyphW-1:0] want,
                            input logic [GlyphW-1:0] got);
    mismatch_cnt++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
        $display("%0t: no completion within %0d cycles", $time, CycleLimit);
        $display("TB_ERROR");
        $finish;
      end else begin
        req_taken = in_valid && in_ready;
        if (req_taken) begin
          shade_q.push_back(shade_pixel(pos_x, pos_y));
          pixels_taken++;
        end
        if (out_valid && out_ready) begin
          got_shade = '{in_disc: inside_res, level: level, glyph: glyph};
          if (shade_q.size() == 0) begin
            mismatch_cnt++;
            $display("%0t: result with no request pending, expected none, got %0b/%0d/%0d",
                     $time, inside_res, level, glyph);
          end else begin
            want_shade = shade_q.pop_front();
            if (got_shade.in_disc !== want_shade.in_disc)
              flag_field("inside_res", GlyphW'(want_shade.in_disc),
                         GlyphW'(got_shade.in_disc));
            if (got_shade.level !== want_shade.level)
              flag_field("level", GlyphW'(want_shade.level), GlyphW'(got_shade.level));
            if (got_shade.glyph !== want_shade.glyph)
              flag_field("glyph", want_shade.glyph, got_shade.glyph);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic add_pixel(input int x, input int y);
    pixel_q.push_back('{x: PosW'(x), y: PosW'(y)});
    pixels_queued++;
  endtask

  // sender holds off until every owed shade has come back
  task automatic wait_drained();
    while (pixels_taken != pixels_queued || shade_q.size() != 0) @(negedge clk_i);
  endtask

  // bits above the register width carry noise, the block must drop them
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    logic [CfgDataW-1:0] data;
    data = CfgDataW'($urandom());
    case (idx)
      RegRadiusSq: begin
        data         = val;
        m_radius_sq  = data[RadSqW-1:0];
      end
      RegInvRadius: begin
        data[InvRW-1:0] = val[InvRW-1:0];
        m_inv_radius    = data[InvRW-1:0];
      end
      RegLightX: begin
        data[LightW-1:0] = val[LightW-1:0];
        m_light_x        = data[LightW-1:0];
      end
      RegLightY: begin
        data[LightW-1:0] = val[LightW-1:0];
        m_light_y        = data[LightW-1:0];
      end
      RegLightZ: begin
        data[LightW-1:0] = val[LightW-1:0];
        m_light_z        = data[LightW-1:0];
      end
      RegAmbient: begin
        data[AmbW-1:0] = val[AmbW-1:0];
        m_ambient      = data[AmbW-1:0];
      end
      RegGain: begin
        data[GainW-1:0] = val[GainW-1:0];
        m_gain          = data[GainW-1:0];
      end
      default: ;  // unmapped index, the block ignores it
    endcase
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
  endtask

  // one full register setting, extremes in the first phases, plausible later
  task automatic apply_setting(input int k);
    int unsigned         r;
    logic [CfgDataW-1:0] rsq;
    int                  inv;
    int                  lx;
    int                  ly;
    int                  lz;
    int                  amb;
    int                  gn;
    r   = $urandom_range(256, 32767);
    rsq = CfgDataW'(r * r);
    inv = (1 << 24) / r;
    lx  = int'($urandom_range(0, 32768)) - 16384;
    ly  = int'($urandom_range(0, 32768)) - 16384;
    lz  = int'($urandom_range(0, 32768)) - 16384;
    amb = $urandom_range(0, 512);
    gn  = $urandom_range(0, 4095);
    case (k)
      1: begin  // largest legal radius, full gain, no ambient
        rsq = 31'd1 << 30; inv = 65536; lx = 16384; ly = 0; lz = 0; amb = 0; gn = 8191;
      end
      2: rsq = '0;  // empty disc
      3: begin  // every register at an extreme of its range
        rsq = 31'h7fffffff; inv = 131071; lx = -32768; ly = 32767; lz = -32768;
        amb = 4095; gn = 8191;
      end
      4: inv = 0;   // zero normal, ambient only
      5: begin
        gn = 0; amb = 4095; lx = -16384; ly = -16384; lz = 16384;
      end
      6: begin  // head-on light
        lx = 0; ly = 0; lz = 16384;
      end
      default: ;
    endcase
    write_reg(RegRadiusSq, rsq);
    write_reg(RegInvRadius, CfgDataW'(inv));
    write_reg(RegLightX, CfgDataW'(lx));
    write_reg(RegLightY, CfgDataW'(ly));
    write_reg(RegLightZ, CfgDataW'(lz));
    write_reg(RegAmbient, CfgDataW'(amb));
    write_reg(RegGain, CfgDataW'(gn));
    write_reg(RegUnused, CfgDataW'($urandom()));
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // mostly points in the square around the disc, the rest anywhere
  task automatic queue_random(input int n);
    int unsigned span;
    span = 32'(floor_sqrt(m_radius_sq));
    if (span > 32767) span = 32767;
    repeat (n) begin
      if ($urandom_range(0, 9) < 7)
        add_pixel(int'($urandom_range(0, 2 * span)) - int'(span),
                  int'($urandom_range(0, 2 * span)) - int'(span));
      else
        add_pixel($urandom(), $urandom());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset setting: radius 20.0, so the disc edge sits at 5120
    add_pixel(0, 0);           add_pixel(5119, 0);
    add_pixel(5120, 0);        add_pixel(0, -5120);
    add_pixel(-5119, 0);       add_pixel(0, 5119);
    add_pixel(3620, -3620);    add_pixel(-3620, 3620);
    add_pixel(1, -1);          add_pixel(-1, 1);
    add_pixel(-32768, -32768); add_pixel(32767, 32767);
    add_pixel(-32768, 32767);  add_pixel(32767, -32768);
    add_pixel(-32768, 0);      add_pixel(0, -32768);
    add_pixel(16'h5555, 16'haaaa);
    add_pixel(16'haaaa, 16'h5555);
    add_pixel(2000, -1000);    add_pixel(-4000, -2500);
    wait_drained();

    for (int k = 1; k <= PhaseCount; k++) begin
      // last phase runs at full rate on both sides
      if (k == PhaseCount) idle_on = 1'b0;
      apply_setting(k);
      queue_random(PixelsPerPhase);
      wait_drained();
    end

    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
